FILE: src/stepper_speed_ramp_timer_period_macros.svh
// Assertion macros for the stepper speed ramp block.
// Used by the controller; no other dependencies.
`ifndef STEPPER_SPEED_RAMP_TIMER_PERIOD_MACROS_SVH
`define STEPPER_SPEED_RAMP_TIMER_PERIOD_MACROS_SVH

// same-cycle implication
`define SSPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSPT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sspt_pkg.sv
// Shared types and constants for the stepper speed ramp block.
// No dependencies.
package sspt_pkg;

  localparam int SPEED_W = 16;
  localparam int COEF_W  = 24;
  localparam int COUNT_W = 32;
  localparam int MOTOR_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // shared divider: dividend 2*coef+speed, divisor up to 2*speed
  localparam int DIV_W = 26;
  localparam int DVS_W = 17;
  localparam int REM_W = 18;
  localparam int CNT_W = 5;
  localparam int PER_W = 25;
  localparam int PRE_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COEF   = 2'd2;

  localparam logic [SPEED_W-1:0] RST_RAMP_STEP     = 16'd1;
  localparam logic [SPEED_W-1:0] RST_RAMP_INTERVAL = 16'd10;
  localparam logic [COEF_W-1:0]  RST_PERIOD_COEF   = 24'd337500;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic eval;
    logic div1_load;
    logic div2_load;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_scan;
    logic motor_ok;
    logic need_timer;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/sspt_if.sv
// Channel interfaces: input words, result words, configuration writes.
// Depends on sspt_pkg.
interface sspt_item_if;
  import sspt_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [MOTOR_W-1:0] motor;
  logic               enable;
  logic [SPEED_W-1:0] target_speed;
  logic               scan_end;
  modport source (output valid, command, motor, enable, target_speed, scan_end,
                  input ready);
  modport sink (input valid, command, motor, enable, target_speed, scan_end,
                output ready);
endinterface

interface sspt_result_if;
  import sspt_pkg::*;
  logic               valid;
  logic               ready;
  logic [MOTOR_W-1:0] motor_out;
  logic               timer_on;
  logic [SPEED_W-1:0] speed_now;
  logic               timer_updated;
  logic [SPEED_W-1:0] reload_value;
  logic [SPEED_W-1:0] prescale_value;
  logic [SPEED_W-1:0] compare_value;
  modport source (output valid, motor_out, timer_on, speed_now, timer_updated,
                  reload_value, prescale_value, compare_value, input ready);
  modport sink (input valid, motor_out, timer_on, speed_now, timer_updated,
                reload_value, prescale_value, compare_value, output ready);
endinterface

interface sspt_cfg_if;
  import sspt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/sspt_datapath.sv
// Datapath: config registers, speed store, interval counter, ramp logic,
// shared bit-serial divider and output register. Depends on sspt_pkg, sspt_if.
module sspt_datapath #(
  parameter int MOTOR_COUNT = 5
) (
  input  logic            clk,
  input  logic            rst,
  sspt_item_if.sink       item,
  sspt_result_if.source   result,
  sspt_cfg_if.sink        cfg,
  input  sspt_pkg::cmd_t  cmd,
  output sspt_pkg::sts_t  sts
);
  import sspt_pkg::*;

  localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic [SPEED_W-1:0] ramp_step;
  logic [SPEED_W-1:0] ramp_interval;
  logic [COEF_W-1:0]  period_coef;

  logic [SPEED_W-1:0] speed_store [MOTOR_COUNT];
  logic [COUNT_W-1:0] interval_count;
  logic               adjusted;

  logic [MOTOR_W-1:0] it_motor;
  logic               it_enable;
  logic [SPEED_W-1:0] it_target;
  logic               it_end;

  logic               res_on;
  logic               res_upd;
  logic [SPEED_W-1:0] res_speed;
  logic [PRE_W-1:0]   res_pre;

  logic [DIV_W-1:0]   d_q;
  logic [REM_W-2:0]   d_rem;
  logic [DVS_W-1:0]   d_div;
  logic [CNT_W-1:0]   d_cnt;

  logic               out_valid;

  logic               motor_ok;
  logic [IW-1:0]      idx;
  logic [SPEED_W-1:0] cur;
  logic               ramp_ok;
  logic [SPEED_W:0]   up;
  logic [SPEED_W-1:0] up_c;
  logic [SPEED_W-1:0] dn;
  logic [SPEED_W-1:0] dn_c;
  logic [SPEED_W-1:0] new_speed;
  logic               adj;
  logic               need_timer;
  logic               adj_any;
  logic [REM_W-1:0]   rem_sh;
  logic               ge;
  logic [PER_W-1:0]   per;
  logic [SPEED_W-1:0] per2;

  assign item.ready = cmd.in_ready && !rst;
  assign cfg.ready  = !rst;

  assign motor_ok = (32'(it_motor) < MOTOR_COUNT);
  assign idx      = IW'(it_motor);

  always_comb begin
    cur     = motor_ok ? speed_store[idx] : '0;
    ramp_ok = (cur != it_target) && (interval_count > 32'(ramp_interval));
    up      = {1'b0, cur} + {1'b0, ramp_step};
    up_c    = (up > {1'b0, it_target}) ? it_target : up[SPEED_W-1:0];
    dn      = (cur >= ramp_step) ? cur - ramp_step : '0;
    dn_c    = (dn < it_target) ? it_target : dn;
    adj     = 1'b0;
    if (!it_enable) begin
      new_speed = '0;
    end else if (ramp_ok) begin
      new_speed = (cur < it_target) ? up_c : dn_c;
      adj       = 1'b1;
    end else begin
      new_speed = cur;
    end
    need_timer = adj && (new_speed != '0);
    adj_any    = adjusted | (motor_ok & adj);
  end

  always_comb begin
    rem_sh = {d_rem, d_q[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, d_div});
    per    = (d_q[PER_W-1:0] == '0) ? PER_W'(1) : d_q[PER_W-1:0];
    per2   = d_q[SPEED_W-1:0];
  end

  assign sts.in_valid   = item.valid;
  assign sts.in_scan    = item.command;
  assign sts.motor_ok   = motor_ok;
  assign sts.need_timer = need_timer;
  assign sts.div_last   = (d_cnt == CNT_W'(DIV_W - 1));
  assign sts.out_free   = !out_valid || result.ready;

  // config and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step      <= RST_RAMP_STEP;
      ramp_interval  <= RST_RAMP_INTERVAL;
      period_coef    <= RST_PERIOD_COEF;
      interval_count <= '0;
      adjusted       <= 1'b0;
      out_valid      <= 1'b0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        speed_store[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_RAMP_STEP:     ramp_step     <= cfg.data[SPEED_W-1:0];
          REG_RAMP_INTERVAL: ramp_interval <= cfg.data[SPEED_W-1:0];
          REG_PERIOD_COEF:   period_coef   <= cfg.data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && !item.command && (interval_count != '1)) begin
        interval_count <= interval_count + COUNT_W'(1);
      end
      if (cmd.eval) begin
        if (motor_ok) begin
          speed_store[idx] <= new_speed;
        end
        if (it_end) begin
          if (adj_any) begin
            interval_count <= '0;
          end
          adjusted <= 1'b0;
        end else begin
          adjusted <= adj_any;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_motor  <= item.motor;
      it_enable <= item.enable;
      it_target <= item.target_speed;
      it_end    <= item.scan_end;
    end
    if (cmd.eval) begin
      res_on    <= it_enable && (new_speed != '0);
      res_upd   <= need_timer;
      res_speed <= new_speed;
    end
    if (cmd.div1_load) begin
      d_q   <= {1'b0, period_coef, 1'b0} + DIV_W'(new_speed);
      d_div <= {new_speed, 1'b0};
      d_rem <= '0;
      d_cnt <= '0;
    end else if (cmd.div2_load) begin
      res_pre <= per[PER_W-1:SPEED_W];
      d_q     <= DIV_W'(per);
      d_div   <= DVS_W'(per[PER_W-1:SPEED_W]) + DVS_W'(1);
      d_rem   <= '0;
      d_cnt   <= '0;
    end else if (cmd.div_step) begin
      d_rem <= ge ? (rem_sh[REM_W-2:0] - d_div[REM_W-2:0]) : rem_sh[REM_W-2:0];
      d_q   <= {d_q[DIV_W-2:0], ge};
      d_cnt <= d_cnt + CNT_W'(1);
    end
    if (cmd.emit) begin
      result.motor_out      <= it_motor;
      result.timer_on       <= res_on;
      result.speed_now      <= res_speed;
      result.timer_updated  <= res_upd;
      result.reload_value   <= res_upd ? per2 - SPEED_W'(1) : '0;
      result.prescale_value <= res_upd ? SPEED_W'(res_pre) : '0;
      result.compare_value  <= res_upd ? {1'b0, per2[SPEED_W-1:1]} : '0;
    end
  end

  assign result.valid = out_valid;

endmodule

FILE: src/sspt_ctrl.sv
// Controller FSM: sequences accept, ramp evaluation, two divisions, result.
// Depends on sspt_pkg and the assertion macro header.
module sspt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  sspt_pkg::sts_t  sts,
  output sspt_pkg::cmd_t  cmd
);
  import sspt_pkg::*;
  `include "stepper_speed_ramp_timer_period_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_MID  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_scan) state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.motor_ok) begin
          state_next = S_IDLE;
        end else if (sts.need_timer) begin
          cmd.div1_load = 1'b1;
          state_next    = S_DIV1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_MID;
      end
      S_MID: begin
        cmd.div2_load = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SSPT_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, sts.out_free, "result overwritten")
  `SSPT_ASSERT_IMP(a_eval_after_idle, clk, rst, state == S_EVAL, $past(state) == S_IDLE, "bad eval entry")
  `SSPT_ASSERT_NXT(a_div1_to_mid, clk, rst, (state == S_DIV1) && sts.div_last, state == S_MID, "divider overrun")

endmodule

FILE: src/stepper_speed_ramp_timer_period.sv
// Stepper speed ramp with step timer setup. A tick word is taken every cycle while
// idle. A scan word for a motor out of range gives no result; any other goes to the
// output register after ramp evaluation, with a timer update only after two 26-step
// passes of the shared bit-serial divider and a load state between them. Handoff
// waits for a free output register; the next word is accepted the cycle after it.
// Synchronous reset: speeds and counter cleared, registers at their defaults.
module stepper_speed_ramp_timer_period #(
  parameter int MOTOR_COUNT = 5
) (
  input logic           clk,
  input logic           rst,
  sspt_item_if.sink     item,
  sspt_result_if.source result,
  sspt_cfg_if.sink      cfg
);
  import sspt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sspt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sspt_datapath #(.MOTOR_COUNT(MOTOR_COUNT)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_speed_ramp_timer_period: ramp and timer
// setup predicted per accepted word, results compared in order. Depends on sspt_pkg
// and the channel interfaces in sspt_if.sv.
module tb;
  import sspt_pkg::*;

  localparam int          MOTORS        = 5;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          LIMIT         = 800000;
  localparam logic        CMD_TICK      = 1'b0;
  localparam logic        CMD_SCAN      = 1'b1;
  localparam logic [1:0]  REG_SPARE     = 2'd3;

  typedef struct {
    logic               command;
    logic [MOTOR_W-1:0] motor;
    logic               enable;
    logic [SPEED_W-1:0] target;
    logic               pass_end;
  } item_word_t;

  typedef struct {
    logic [MOTOR_W-1:0] motor;
    logic               timer_on;
    logic [SPEED_W-1:0] speed;
    logic               updated;
    logic [SPEED_W-1:0] reload;
    logic [SPEED_W-1:0] prescale;
    logic [SPEED_W-1:0] compare;
  } motor_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sspt_item_if   item_ch ();
  sspt_result_if report_ch ();
  sspt_cfg_if    cfg_ch ();

  stepper_speed_ramp_timer_period #(.MOTOR_COUNT(MOTORS)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (report_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_word_t    cmd_words[$];
  motor_report_t motor_reports[$];
  item_word_t    next_word;
  bit            word_taken = 1'b0;
  int            idle_pct   = 22;
  int            fail_count = 0;
  int            cycle_no   = 0;

  // mirrored block state
  logic [SPEED_W-1:0] speed_mirror[MOTORS];
  logic [COUNT_W-1:0] tick_count    = '0;
  bit                 pass_adjusted = 1'b0;
  logic [SPEED_W-1:0] step_cfg      = RST_RAMP_STEP;
  logic [SPEED_W-1:0] interval_cfg  = RST_RAMP_INTERVAL;
  logic [COEF_W-1:0]  coef_cfg      = RST_PERIOD_COEF;

  // per-motor stimulus targets
  logic [SPEED_W-1:0] aim[MOTORS];
  bit                 aim_on[MOTORS];

  initial begin
    for (int m = 0; m < MOTORS; m++) begin
      speed_mirror[m] = '0;
      aim[m]          = '0;
      aim_on[m]       = 1'b1;
    end
  end

  function automatic void period_setup(input logic [SPEED_W-1:0] spd,
                                       output logic [SPEED_W-1:0] rel, pre, cmp);
    logic [63:0] per;
    logic [63:0] dv;
    per = (64'(coef_cfg) * 2 + 64'(spd)) / (64'(spd) * 2);
    if (per == 0) per = 1;
    dv  = per >> 16;
    per = per / (dv + 1);
    rel = 16'(per - 1);
    pre = 16'(dv);
    cmp = 16'(per / 2);
  endfunction

  function automatic void ramp_motor(item_word_t w);
    motor_report_t r;
    logic [16:0]   spd;
    if (w.command == CMD_TICK) begin
      if (tick_count != '1) tick_count++;
      return;
    end
    if (w.motor < MOTORS) begin
      spd = {1'b0, speed_mirror[w.motor]};
      r.motor    = w.motor;
      r.timer_on = 1'b0;
      r.updated  = 1'b0;
      r.reload   = '0;
      r.prescale = '0;
      r.compare  = '0;
      if (!w.enable) begin
        spd = '0;
      end else begin
        if (spd != w.target && tick_count > interval_cfg) begin
          if (spd < w.target) begin
            spd = spd + step_cfg;
            if (spd > w.target) spd = w.target;
          end else begin
            spd = (spd >= step_cfg) ? spd - step_cfg : '0;
            if (spd < w.target) spd = w.target;
          end
          pass_adjusted = 1'b1;
          if (spd != 0) begin
            period_setup(spd[15:0], r.reload, r.prescale, r.compare);
            r.updated = 1'b1;
          end
        end
        r.timer_on = (spd != 0);
      end
      speed_mirror[w.motor] = spd[15:0];
      r.speed = spd[15:0];
      motor_reports.push_back(r);
    end
    if (w.pass_end) begin
      if (pass_adjusted) tick_count = '0;
      pass_adjusted = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // word driver
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || word_taken) begin
      word_taken = 1'b0;
      if (cmd_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_word = cmd_words.pop_front();
        item_ch.valid        <= 1'b1;
        item_ch.command      <= next_word.command;
        item_ch.motor        <= next_word.motor;
        item_ch.enable       <= next_word.enable;
        item_ch.target_speed <= next_word.target;
        item_ch.scan_end     <= next_word.pass_end;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      report_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : sample
    item_word_t    w;
    motor_report_t e;
    cycle_no++;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        w.command  = item_ch.command;
        w.motor    = item_ch.motor;
        w.enable   = item_ch.enable;
        w.target   = item_ch.target_speed;
        w.pass_end = item_ch.scan_end;
        ramp_motor(w);
        word_taken = 1'b1;
      end
      if (report_ch.valid && report_ch.ready) begin
        if (motor_reports.size() == 0) begin
          $display("%0t: result for motor %0d with none expected", $time,
                   report_ch.motor_out);
          fail_count++;
        end else begin
          e = motor_reports.pop_front();
          check_field("motor_out", e.motor, report_ch.motor_out);
          check_field("timer_on", e.timer_on, report_ch.timer_on);
          check_field("speed_now", e.speed, report_ch.speed_now);
          check_field("timer_updated", e.updated, report_ch.timer_updated);
          check_field("reload_value", e.reload, report_ch.reload_value);
          check_field("prescale_value", e.prescale, report_ch.prescale_value);
          check_field("compare_value", e.compare, report_ch.compare_value);
        end
      end
    end
  end

  initial begin
    while (cycle_no < LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic push_word(logic cmd, logic [MOTOR_W-1:0] m, logic en,
                           logic [SPEED_W-1:0] tgt, logic pe);
    item_word_t w;
    w.command  = cmd;
    w.motor    = m;
    w.enable   = en;
    w.target   = tgt;
    w.pass_end = pe;
    cmd_words.push_back(w);
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++)
      push_word(CMD_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)),
                16'($urandom), 1'($urandom_range(1)));
  endtask

  function automatic logic [SPEED_W-1:0] pick_target();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      3:       return 16'($urandom_range(1, 60));
      default: return 16'($urandom_range(4000));
    endcase
  endfunction

  task automatic settle();
    while (cmd_words.size() != 0 || item_ch.valid || motor_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_RAMP_STEP:     step_cfg     = data[SPEED_W-1:0];
      REG_RAMP_INTERVAL: interval_cfg = data[SPEED_W-1:0];
      REG_PERIOD_COEF:   coef_cfg     = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_regs(logic [SPEED_W-1:0] stp, logic [SPEED_W-1:0] ivl,
                           logic [COEF_W-1:0] cf);
    write_reg(REG_RAMP_STEP, CFG_DAT_W'(stp));
    write_reg(REG_RAMP_INTERVAL, CFG_DAT_W'(ivl));
    write_reg(REG_PERIOD_COEF, cf);
  endtask

  // mostly full scan passes after a few ticks; the rest is loose noise
  task automatic traffic(int n);
    int made;
    int pause_at;
    int tick_max;
    int ticks;
    made     = 0;
    pause_at = n / 2;
    while (made < n) begin
      if ($urandom_range(99) < 80) begin
        tick_max = (interval_cfg < 30) ? int'(interval_cfg) + 4 : 6;
        ticks    = $urandom_range(tick_max);
        push_ticks(ticks);
        made += ticks;
        for (int m = 0; m < MOTORS; m++) begin
          if ($urandom_range(7) == 0) aim[m] = pick_target();
          if ($urandom_range(15) == 0) aim_on[m] = !aim_on[m];
          push_word(CMD_SCAN, 3'(m), aim_on[m], aim[m],
                    (m == MOTORS - 1) && ($urandom_range(9) != 0));
          made++;
        end
      end else begin
        push_word(1'($urandom_range(1)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                  pick_target(), 1'($urandom_range(1)));
        made++;
      end
      if (made >= pause_at) begin
        settle();
        pause_at = n + 1;
      end
    end
  endtask

  initial begin
    item_ch.valid        = 1'b0;
    item_ch.command      = CMD_TICK;
    item_ch.motor        = '0;
    item_ch.enable       = 1'b0;
    item_ch.target_speed = '0;
    item_ch.scan_end     = 1'b0;
    report_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_RAMP_STEP;
    cfg_ch.data          = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_regs(16'd1000, 16'd0, RST_PERIOD_COEF);
    push_word(CMD_TICK, 3'd7, 1'b1, 16'hFFFF, 1'b1);   // tick ignores its fields
    push_word(CMD_SCAN, 3'd0, 1'b1, 16'hFFFF, 1'b0);
    push_word(CMD_SCAN, 3'd1, 1'b1, 16'd500, 1'b0);    // clamps at target
    push_word(CMD_SCAN, 3'd2, 1'b0, 16'hFFFF, 1'b0);   // disabled
    push_word(CMD_SCAN, 3'd7, 1'b1, 16'd1, 1'b1);      // no such motor, ends pass
    push_word(CMD_SCAN, 3'd0, 1'b1, 16'd0, 1'b1);      // counter cleared: hold
    push_word(CMD_TICK, 3'd0, 1'b0, 16'd0, 1'b0);
    push_word(CMD_SCAN, 3'd0, 1'b1, 16'd0, 1'b0);      // ramps down to zero
    push_word(CMD_SCAN, 3'd4, 1'b1, 16'hFFFF, 1'b1);
    push_word(CMD_TICK, 3'd5, 1'b1, 16'h0000, 1'b0);
    push_word(CMD_SCAN, 3'd4, 1'b1, 16'd300, 1'b0);    // down, clamps at target
    push_word(CMD_SCAN, 3'd3, 1'b1, 16'hFFFF, 1'b1);
    push_word(CMD_TICK, 3'd2, 1'b0, 16'h5555, 1'b1);
    push_word(CMD_SCAN, 3'd1, 1'b0, 16'd500, 1'b1);
    push_word(CMD_SCAN, 3'd6, 1'b0, 16'hAAAA, 1'b0);
    settle();

    load_regs(RST_RAMP_STEP, RST_RAMP_INTERVAL, RST_PERIOD_COEF);
    traffic(100);
    settle();

    load_regs(16'd1, 16'd0, 24'd1);                    // tiny periods
    traffic(100);
    settle();

    idle_pct = 0;
    load_regs(16'hFFFF, 16'd40, 24'hFFFFFF);
    push_ticks(42);
    traffic(60);
    settle();
    idle_pct = 22;

    load_regs(16'd0, 16'd2, 24'($urandom));            // zero step
    traffic(100);
    settle();

    write_reg(REG_SPARE, 24'hFFFFFF);
    load_regs(16'($urandom_range(1, 3000)), 16'($urandom_range(8)),
              24'($urandom_range(1, 24'hFFFFFF)));
    traffic(130);
    settle();

    idle_pct = 0;
    load_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(3)),
              24'($urandom_range(1, 2000000)));
    traffic(80);
    settle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
